// File: hdl/prt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prt_pkg - shared definitions of the prefix routing table
// Opcodes, status codes, field widths and the records passed between cells.
// ----------------------------------------------------------------------------
package prt_pkg;

	localparam int TABLE_DEPTH_DEF = 16;

	localparam int OPC_W   = 2;
	localparam int ADDR_W  = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISS = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 72;

	// One stored route.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] network;
		logic [ADDR_W-1:0] netmask;
	} entry_t;

	// Scan record handed from cell to cell.
	typedef struct packed {
		logic              hit;     // a matching entry was seen upstream
		logic              passed;  // the insert position lies upstream
		logic [ADDR_W-1:0] network;
		logic [ADDR_W-1:0] netmask;
	} token_t;

	// Table update command broadcast to all cells.
	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage : prt_pkg
`default_nettype wire

// File: hdl/prt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prt_cell - one slot of the routing table
// Holds one route, compares it with the request, forwards the scan record and
// shifts its entry from a neighbor, or takes the new route, when an insert or remove is committed.
// ----------------------------------------------------------------------------
module prt_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire [prt_pkg::OPC_W-1:0]     req_op,
	input  wire [prt_pkg::ADDR_W-1:0]    req_addr,
	input  wire [prt_pkg::ADDR_W-1:0]    req_mask,
	input  prt_pkg::cmd_t                cmd,
	input  prt_pkg::entry_t              left_entry,
	input  prt_pkg::entry_t              right_entry,
	input  prt_pkg::token_t              tok_in,
	output prt_pkg::token_t              tok_out,
	output prt_pkg::entry_t              entry
);
	import prt_pkg::*;

	entry_t entry_q;
	token_t tok_q;
	logic   exact;
	logic   look_hit;
	logic   hit_local;
	logic   at_pos;
	token_t tok_next;

	always_comb begin
		exact     = entry_q.valid && (entry_q.network == req_addr) &&
		            (entry_q.netmask == req_mask);
		look_hit  = entry_q.valid && (entry_q.network == (req_addr & entry_q.netmask));
		hit_local = ((req_op == OP_INSERT || req_op == OP_REMOVE) && exact) ||
		            ((req_op == OP_LOOKUP) && look_hit);
		// Entries are contiguous, so the first empty slot also qualifies.
		at_pos    = !tok_in.passed && (!entry_q.valid || (entry_q.netmask <= req_mask));

		tok_next.hit    = tok_in.hit || hit_local;
		tok_next.passed = tok_in.passed || at_pos;
		if (tok_in.hit) begin
			tok_next.network = tok_in.network;
			tok_next.netmask = tok_in.netmask;
		end else if (hit_local) begin
			tok_next.network = entry_q.network;
			tok_next.netmask = entry_q.netmask;
		end else begin
			tok_next.network = '0;
			tok_next.netmask = '0;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (cmd.ins) begin
			if (at_pos) begin
				entry_q.valid   <= 1'b1;
				entry_q.network <= req_addr;
				entry_q.netmask <= req_mask;
			end else if (tok_in.passed) begin
				entry_q <= left_entry;
			end
		end else if (cmd.rem) begin
			if (tok_in.hit || hit_local) begin
				entry_q <= right_entry;
			end
		end
	end

	assign tok_out = tok_q;
	assign entry   = entry_q;

endmodule : prt_cell
`default_nettype wire

// File: hdl/prefix_routing_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_routing_table_unit - longest prefix match routing table
// A row of cells keeps network/mask routes in order of descending mask and
// serves insert, remove and lookup requests.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel, one item per request, and each gives
// exactly one result item on the m_axis channel. An insert places the route
// ahead of the first entry whose mask is not greater, or reports a duplicate
// or a full table. A remove deletes an exact match. A lookup returns the first
// entry whose network equals the address ANDed with its mask, which, thanks to
// the ordering, is the longest prefix.
// Each accepted item sends a scan record down the row of cells, one cell per
// cycle. The commit state then applies the table update and loads the result
// register. The block takes no new item until it is through with the last.
// s_axis_tready is high only while no item is at work. A waiting result does
// not block acceptance of the next item; a stalled receiver holds the next
// result in its commit state until the output register is free.
// Reset clears every cell's entry, the entry count and the output valid flag.
// ----------------------------------------------------------------------------
module prefix_routing_table_unit #(
	parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_axis_tvalid,
	output logic                           s_axis_tready,
	// opcode [1:0], address [33:2], mask [65:34], zero padding above
	input  wire [prt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  wire                            m_axis_tready,
	// status [1:0], route_network [33:2], route_mask [65:34],
	// entry_count [70:66], zero padding above
	output logic [prt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import prt_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = $clog2(TABLE_DEPTH);

	// Controller state codes.
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic [OPC_W-1:0]  req_op_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [ADDR_W-1:0] req_mask_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ADDR_W-1:0] out_net_q;
	logic [ADDR_W-1:0] out_mask_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              s_accept;
	logic              finish;
	logic              table_full;
	token_t            tail;
	cmd_t              cmd;
	logic [STAT_W-1:0] res_status;
	logic [ADDR_W-1:0] res_net;
	logic [ADDR_W-1:0] res_mask;
	logic [CNT_W-1:0]  res_count;

	entry_t ent [TABLE_DEPTH];
	token_t tok [TABLE_DEPTH+1];

	assign s_axis_tready = (state_q == S_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	// The result slot is free, or is being emptied in this cycle.
	assign finish     = (state_q == S_COMMIT) && (!out_valid_q || m_axis_tready);
	assign table_full = (count_q == CNT_W'(TABLE_DEPTH));
	assign tail       = tok[TABLE_DEPTH];

	// The scan record enters the first cell empty.
	assign tok[0] = '0;

	// Outcome of the request once the scan record has left the last cell.
	always_comb begin
		res_status = ST_MISS;
		res_net    = '0;
		res_mask   = '0;
		res_count  = count_q;
		cmd        = '0;
		unique case (req_op_q)
			OP_INSERT: begin
				if (tail.hit) begin
					res_status = ST_DUP;
					res_net    = tail.network;
					res_mask   = tail.netmask;
				end else if (table_full) begin
					res_status = ST_FULL;
				end else begin
					res_status = ST_OK;
					res_net    = req_addr_q;
					res_mask   = req_mask_q;
					res_count  = count_q + CNT_W'(1);
					cmd.ins    = finish;
				end
			end
			OP_REMOVE: begin
				if (tail.hit) begin
					res_status = ST_OK;
					res_net    = req_addr_q;
					res_mask   = req_mask_q;
					res_count  = count_q - CNT_W'(1);
					cmd.rem    = finish;
				end
			end
			OP_LOOKUP: begin
				if (tail.hit) begin
					res_status = ST_OK;
					res_net    = tail.network;
					res_mask   = tail.netmask;
				end
			end
			default: begin
				// The unused opcode changes nothing and reports a miss.
			end
		endcase
	end

	// Request register and sequencing of scan and commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						state_q <= S_SCAN;
						step_q  <= '0;
					end
				end
				S_SCAN: begin
					if (step_q == IDX_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_COMMIT;
					end else begin
						step_q <= step_q + IDX_W'(1);
					end
				end
				S_COMMIT: begin
					if (finish) begin
						state_q <= S_IDLE;
						count_q <= res_count;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			req_op_q   <= s_axis_tdata[OPC_W-1:0];
			req_addr_q <= s_axis_tdata[OPC_W +: ADDR_W];
			req_mask_q <= s_axis_tdata[OPC_W+ADDR_W +: ADDR_W];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= res_status;
			out_net_q    <= res_net;
			out_mask_q   <= res_mask;
			out_count_q  <= COUNT_W'(res_count);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(OUT_DATA_W - STAT_W - 2*ADDR_W - COUNT_W)'(0),
		out_count_q, out_mask_q, out_net_q, out_status_q
	};

	// The row of cells; the first and last see empty entries beyond the ends.
	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			if (gi == 0) begin : g_first
				assign left_e = '0;
			end else begin : g_inner_l
				assign left_e = ent[gi-1];
			end
			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign right_e = '0;
			end else begin : g_inner_r
				assign right_e = ent[gi+1];
			end
			prt_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.req_op      (req_op_q),
				.req_addr    (req_addr_q),
				.req_mask    (req_mask_q),
				.cmd         (cmd),
				.left_entry  (left_e),
				.right_entry (right_e),
				.tok_in      (tok[gi]),
				.tok_out     (tok[gi+1]),
				.entry       (ent[gi])
			);
		end
	endgenerate

endmodule : prefix_routing_table_unit
`default_nettype wire

// File: hdl/prt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prt_checker - port-level checks of the prefix routing table
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module prt_checker #(
	parameter int TABLE_DEPTH = prt_pkg::TABLE_DEPTH_DEF
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_axis_tvalid,
	input wire                           s_axis_tready,
	input wire [prt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input wire                           m_axis_tvalid,
	input wire                           m_axis_tready,
	input wire [prt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import prt_pkg::*;

	logic [STAT_W-1:0]  o_status;
	logic [ADDR_W-1:0]  o_net;
	logic [ADDR_W-1:0]  o_mask;
	logic [COUNT_W-1:0] o_count;
	logic               in_seen;

	assign o_status = m_axis_tdata[STAT_W-1:0];
	assign o_net    = m_axis_tdata[STAT_W +: ADDR_W];
	assign o_mask   = m_axis_tdata[STAT_W+ADDR_W +: ADDR_W];
	assign o_count  = m_axis_tdata[STAT_W+2*ADDR_W +: COUNT_W];
	assign in_seen  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[0] || !s_axis_tdata[0]);

	// A pending result stays offered until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result withdrawn before it was taken");

	// A request is scanned cell by cell, so none is taken right after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_seen |=> !s_axis_tready)
		else $error("request accepted while another is at work");

	// Misses and full-table reports carry no route.
	a_empty_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (o_status == ST_MISS || o_status == ST_FULL)
		|-> (o_net == '0) && (o_mask == '0))
		else $error("route fields not zero on a miss or full report");

	// The reported count never exceeds the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (TABLE_DEPTH >= 32) || (int'(o_count) <= TABLE_DEPTH))
		else $error("entry count beyond table size");

endmodule : prt_checker

bind prefix_routing_table_unit prt_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_prt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the prefix routing table
// Sends insert, remove, lookup and unused-opcode requests over the request stream, predicts
// each result with a behavioral copy of the route table, and compares every
// result item field by field, under several patterns of sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_top;

	import prt_pkg::*;

	localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
	localparam int RESULT_LATENCY = TABLE_DEPTH + 2;
	localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ADDR_W-1:0]  network;
		logic [ADDR_W-1:0]  netmask;
		logic [COUNT_W-1:0] count;
	} route_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	// Behavioral copy of the table; slots 0..held_routes-1 are in use.
	logic [ADDR_W-1:0] route_network [TABLE_DEPTH];
	logic [ADDR_W-1:0] route_netmask [TABLE_DEPTH];
	int                held_routes;

	route_result_t pending_results[$];
	int            fail_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;

	prefix_routing_table_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic void clear_route_table();
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			route_network[i] = '0;
			route_netmask[i] = '0;
		end
		held_routes = 0;
	endfunction

	function automatic int find_route(logic [ADDR_W-1:0] net, logic [ADDR_W-1:0] msk);
		for (int i = 0; i < held_routes; i++) begin
			if (route_network[i] == net && route_netmask[i] == msk)
				return i;
		end
		return -1;
	endfunction

	// Applies one request to the table copy and returns the result it gives.
	function automatic route_result_t apply_route_request(logic [OPC_W-1:0] opc,
			logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] msk);
		route_result_t res;
		int hit;
		int pos;
		res = '{status: ST_MISS, network: '0, netmask: '0, count: '0};
		hit = find_route(addr, msk);
		case (opc)
			OP_INSERT: begin
				if (hit >= 0) begin
					res.status  = ST_DUP;
					res.network = route_network[hit];
					res.netmask = route_netmask[hit];
				end else if (held_routes >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					// New route goes ahead of the first entry whose mask is not greater.
					pos = held_routes;
					for (int i = 0; i < held_routes; i++) begin
						if (route_netmask[i] <= msk) begin
							pos = i;
							break;
						end
					end
					for (int i = held_routes; i > pos; i--) begin
						route_network[i] = route_network[i-1];
						route_netmask[i] = route_netmask[i-1];
					end
					route_network[pos] = addr;
					route_netmask[pos] = msk;
					held_routes++;
					res.status  = ST_OK;
					res.network = addr;
					res.netmask = msk;
				end
			end
			OP_REMOVE: begin
				if (hit >= 0) begin
					for (int i = hit; i + 1 < held_routes; i++) begin
						route_network[i] = route_network[i+1];
						route_netmask[i] = route_netmask[i+1];
					end
					held_routes--;
					route_network[held_routes] = '0;
					route_netmask[held_routes] = '0;
					res.status  = ST_OK;
					res.network = addr;
					res.netmask = msk;
				end
			end
			OP_LOOKUP: begin
				// The first match is the longest prefix thanks to the ordering.
				for (int i = 0; i < held_routes; i++) begin
					if (route_network[i] == (addr & route_netmask[i])) begin
						res.status  = ST_OK;
						res.network = route_network[i];
						res.netmask = route_netmask[i];
						break;
					end
				end
			end
			default: ;
		endcase
		res.count = COUNT_W'(held_routes);
		return res;
	endfunction

	// Drives one request, holds it until accepted and records its predicted result.
	task automatic send_request(logic [OPC_W-1:0] opc, logic [ADDR_W-1:0] addr,
			logic [ADDR_W-1:0] msk);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_DATA_W - OPC_W - 2*ADDR_W){1'b0}}, msk, addr, opc};
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(apply_route_request(opc, addr, msk));
	endtask

	// Stops sending and waits until every predicted result has arrived.
	task automatic wait_for_results();
		int guard;
		guard = 0;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() > 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	always @(posedge clk) begin : check_results
		route_result_t seen;
		route_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.status  = m_axis_tdata[1:0];
			seen.network = m_axis_tdata[33:2];
			seen.netmask = m_axis_tdata[65:34];
			seen.count   = m_axis_tdata[70:66];
			if (pending_results.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: status %0d net %h mask %h count %0d",
						seen.status, seen.network, seen.netmask, seen.count);
			end else begin
				want = pending_results.pop_front();
				if (seen.status !== want.status || seen.network !== want.network ||
						seen.netmask !== want.netmask || seen.count !== want.count) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result mismatch: expected status %0d net %h mask %h count %0d, got status %0d net %h mask %h count %0d",
							want.status, want.network, want.netmask, want.count,
							seen.status, seen.network, seen.netmask, seen.count);
				end
			end
		end
	end

	// Routes of several prefix lengths, one with host bits set outside its mask
	// and one tied on mask length with an earlier route.
	task automatic test_insert_order();
		send_request(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000);
		send_request(OP_INSERT, 32'h0A01_0000, 32'hFFFF_0000);
		send_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_INSERT, 32'hC0A8_0100, 32'hFFFF_FF00);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 32'h0A02_00FF, 32'hFFFF_0000);
	endtask

	task automatic test_lookup();
		send_request(OP_LOOKUP, 32'h0A01_0203, 32'hFFFF_FFFF);
		send_request(OP_LOOKUP, 32'h0A7F_0000, 32'h0000_0000);
		send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0F0F_0F0F);
		send_request(OP_LOOKUP, 32'h0B00_0000, 32'h0000_0000);
	endtask

	task automatic test_duplicate_route();
		send_request(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000);
	endtask

	// Removing the default route leaves addresses that no route covers.
	task automatic test_remove();
		send_request(OP_REMOVE, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 32'h1234_5678, 32'hFFFF_0000);
		send_request(OP_LOOKUP, 32'h0B00_0000, 32'hFFFF_FFFF);
	endtask

	task automatic test_unused_opcode();
		send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// Fills the table, then tries a new route and an existing one.
	task automatic test_full_table();
		logic [ADDR_W-1:0] msk;
		for (int k = 0; k < 11; k++) begin
			msk = 32'hFFFF_FFFF << (k + 9);
			send_request(OP_INSERT, $urandom & msk, msk);
		end
		send_request(OP_INSERT, 32'h1234_0000, 32'hFFFF_0000);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	function automatic logic [ADDR_W-1:0] random_netmask();
		int unsigned plen;
		if ($urandom_range(9) == 0)
			return $urandom;
		plen = ($urandom_range(1) == 0) ? $urandom_range(4) * 8 : $urandom_range(32);
		return (plen == 0) ? '0 : (32'hFFFF_FFFF << (32 - plen));
	endfunction

	// Random inserts of mostly new routes, removes and lookups that mostly target
	// routes already held, and the odd unused opcode.
	task automatic test_random_requests(int items, int idle_pct, int stall_pct);
		int unsigned pick;
		int unsigned slot;
		int insert_pct;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] msk;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			slot = (held_routes > 0) ? $urandom_range(held_routes - 1) : 0;
			insert_pct = (held_routes >= TABLE_DEPTH - 2) ? 25 : 45;
			if (pick < insert_pct) begin
				if (held_routes > 0 && $urandom_range(6) == 0) begin
					addr = route_network[slot];
					msk  = route_netmask[slot];
				end else begin
					msk  = random_netmask();
					addr = ($urandom_range(6) == 0) ? $urandom : ($urandom & msk);
				end
				send_request(OP_INSERT, addr, msk);
			end else if (pick < insert_pct + 25) begin
				if (held_routes > 0 && $urandom_range(3) != 0) begin
					addr = route_network[slot];
					msk  = route_netmask[slot];
				end else begin
					msk  = random_netmask();
					addr = (held_routes > 0) ? route_network[slot] : $urandom;
				end
				send_request(OP_REMOVE, addr, msk);
			end else if (pick < 97) begin
				if (held_routes > 0 && $urandom_range(9) < 7)
					addr = route_network[slot] | ($urandom & ~route_netmask[slot]);
				else
					addr = $urandom;
				send_request(OP_LOOKUP, addr, $urandom);
			end else begin
				send_request(OP_UNUSED, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		clear_route_table();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_insert_order();
		test_lookup();
		test_duplicate_route();
		wait_for_results();
		test_remove();
		test_unused_opcode();
		test_full_table();
		wait_for_results();

		test_random_requests(200, 0, 0);
		wait_for_results();
		test_random_requests(200, 54, 0);
		wait_for_results();
		test_random_requests(200, 0, 54);
		wait_for_results();
		test_random_requests(200, 28, 28);
		wait_for_results();

		repeat (RESULT_LATENCY + 4) @(posedge clk);
		if (pending_results.size() > 0) begin
			fail_count++;
			$display("%0d results never arrived", pending_results.size());
		end
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule : tb_top
`default_nettype wire
